/* rtl/abs_pkg.sv */
// Shared types, constants and checksum helpers for the alternating-bit sender.
`default_nettype none

package abs_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_MSG     = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        PH_IDLE0 = 2'd0,
        PH_WAIT0 = 2'd1,
        PH_IDLE1 = 2'd2,
        PH_WAIT1 = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        TMR_NONE       = 2'd0,
        TMR_START      = 2'd1,
        TMR_STOP       = 2'd2,
        TMR_STOP_START = 2'd3
    } timer_t;

    // One queued message plus its folded payload-only checksum sum.
    typedef struct packed {
        logic [63:0] low;
        logic [63:0] mid;
        logic [31:0] high;
        logic [15:0] psum;
    } msg_t;

    // Request captured by the front stage.
    typedef struct packed {
        opcode_t op;
        msg_t    msg;
        logic    ack0;
        logic    ack1;
        logic    sum_ok;
    } req_t;

    typedef struct packed {
        logic push;
        logic pop;
    } qctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    // End-around fold of a sum of up to 16 words; nonzero in gives nonzero out.
    function automatic logic [15:0] fold20(input logic [19:0] s);
        logic [16:0] t;
        t = {1'b0, s[15:0]} + {13'd0, s[19:16]};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    function automatic logic [QIDX_W-1:0] qidx_inc(input logic [QIDX_W-1:0] i);
        return (i == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage

`default_nettype wire

/* rtl/abs_front.sv */
// Input register stage: captures a request and precomputes checksum sums.
`default_nettype none

module abs_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    opcode,
    input  wire logic [63:0]   payload_low,
    input  wire logic [63:0]   payload_mid,
    input  wire logic [31:0]   payload_high,
    input  wire logic [31:0]   pkt_seq,
    input  wire logic [31:0]   pkt_ack,
    input  wire logic [31:0]   pkt_check,
    input  wire logic          adv,
    output logic               req_valid,
    output abs_pkg::req_t      req
);

    logic           req_valid_reg;
    logic           req_valid_next;
    abs_pkg::req_t  req_reg;
    abs_pkg::req_t  req_next;
    logic [159:0]   pay;
    logic [19:0]    pay_sum;
    logic [19:0]    full_sum;

    always_comb
    begin
        pay     = {payload_high, payload_mid, payload_low};
        pay_sum = '0;
        for (int i = 0; i < 10; i++)
        begin
            pay_sum = pay_sum + {4'd0, pay[16*i +: 16]};
        end
        full_sum = pay_sum
                 + {4'd0, pkt_seq[15:0]}   + {4'd0, pkt_seq[31:16]}
                 + {4'd0, pkt_ack[15:0]}   + {4'd0, pkt_ack[31:16]}
                 + {4'd0, pkt_check[15:0]} + {4'd0, pkt_check[31:16]};
    end

    always_comb
    begin
        req_next.op       = abs_pkg::opcode_t'(opcode);
        req_next.msg.low  = payload_low;
        req_next.msg.mid  = payload_mid;
        req_next.msg.high = payload_high;
        req_next.msg.psum = abs_pkg::fold20(pay_sum);
        req_next.ack0     = (pkt_ack == 32'd0);
        req_next.ack1     = (pkt_ack == 32'd1);
        req_next.sum_ok   = (abs_pkg::fold20(full_sum) == 16'hffff);
    end

    assign in_ready = !req_valid_reg || adv;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (in_valid && in_ready)
        begin
            req_valid_next = 1'b1;
        end
        else if (adv)
        begin
            req_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= req_next;
        end
    end

    assign req_valid = req_valid_reg;
    assign req       = req_reg;

endmodule

`default_nettype wire

/* rtl/abs_queue.sv */
// Circular message queue: one synchronous RAM with head read kept current.
`default_nettype none

module abs_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire abs_pkg::qctl_t ctl,
    input  wire abs_pkg::msg_t  wr_data,
    output abs_pkg::msg_t       head_data,
    output abs_pkg::qstat_t     stat
);

    abs_pkg::msg_t                 mem [abs_pkg::QUEUE_DEPTH];
    abs_pkg::msg_t                 rd_reg;
    logic [abs_pkg::QIDX_W-1:0]    head_reg;
    logic [abs_pkg::QIDX_W-1:0]    head_next;
    logic [abs_pkg::QIDX_W-1:0]    tail_reg;
    logic [abs_pkg::QIDX_W-1:0]    tail_next;
    logic [abs_pkg::QCNT_W-1:0]    count_reg;
    logic [abs_pkg::QCNT_W-1:0]    count_next;

    always_comb
    begin
        head_next  = ctl.pop  ? abs_pkg::qidx_inc(head_reg) : head_reg;
        tail_next  = ctl.push ? abs_pkg::qidx_inc(tail_reg) : tail_reg;
        count_next = count_reg;
        if (ctl.push && !ctl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.pop && !ctl.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Read the next head every cycle; forward a same-edge write to that slot.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_reg] <= wr_data;
        end
        if (ctl.push && (tail_reg == head_next))
        begin
            rd_reg <= wr_data;
        end
        else
        begin
            rd_reg <= mem[head_next];
        end
    end

    assign head_data  = rd_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == abs_pkg::QCNT_W'(abs_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

/* rtl/alternating_bit_sender_core.sv */
// Alternating-bit sender top level: request decode, last packet and result register.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_ready   | opcode, payload_low/mid/high, pkt_seq/ack/check
//  out     | out_valid / out_ready | send_valid, out_seq, out_check, out_low/mid/high,
//          |                       | timer_action
//
// One request per cycle sustained while results are taken; a result passes through the
// input register, execute with the queue read-modify-write, and the result register.
// The queue RAM read of the head is registered and refreshed every cycle.
// Reset clears phase, pointers and the last packet; queue RAM contents are not cleared.
// Execute stalls only while the result register holds an untaken result.
`default_nettype none

module alternating_bit_sender_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    opcode,
    input  wire logic [63:0]   payload_low,
    input  wire logic [63:0]   payload_mid,
    input  wire logic [31:0]   payload_high,
    input  wire logic [31:0]   pkt_seq,
    input  wire logic [31:0]   pkt_ack,
    input  wire logic [31:0]   pkt_check,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic               send_valid,
    output logic               out_seq,
    output logic [15:0]        out_check,
    output logic [63:0]        out_low,
    output logic [63:0]        out_mid,
    output logic [31:0]        out_high,
    output logic [1:0]         timer_action
);

    logic               req_valid;
    abs_pkg::req_t      req;
    logic               adv;
    abs_pkg::qctl_t     qctl;
    abs_pkg::qstat_t    qstat;
    abs_pkg::msg_t      head_data;

    abs_pkg::phase_t    phase_reg;
    abs_pkg::phase_t    phase_next;

    logic               last_seq_reg,   last_seq_next;
    logic [15:0]        last_check_reg, last_check_next;
    abs_pkg::msg_t      last_msg_reg,   last_msg_next;

    logic               load;
    logic               from_queue;
    logic               new_seq;
    logic               res;
    logic               send;
    abs_pkg::timer_t    timer;
    logic               want_ok;
    abs_pkg::msg_t      src;
    logic [16:0]        chk_sum;

    logic               out_valid_reg,  out_valid_next;
    logic               send_reg;
    logic               seq_reg;
    logic [15:0]        check_reg;
    logic [63:0]        low_reg;
    logic [63:0]        mid_reg;
    logic [31:0]        high_reg;
    abs_pkg::timer_t    timer_reg;

    abs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .payload_low  (payload_low),
        .payload_mid  (payload_mid),
        .payload_high (payload_high),
        .pkt_seq      (pkt_seq),
        .pkt_ack      (pkt_ack),
        .pkt_check    (pkt_check),
        .adv          (adv),
        .req_valid    (req_valid),
        .req          (req)
    );

    abs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (qctl),
        .wr_data   (req.msg),
        .head_data (head_data),
        .stat      (qstat)
    );

    assign adv = req_valid && (!out_valid_reg || out_ready);

    assign want_ok = (phase_reg == abs_pkg::PH_WAIT0) ? req.ack0 : req.ack1;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (adv)
        begin
            unique case (req.op)
                abs_pkg::OP_MSG:
                begin
                    if (phase_reg == abs_pkg::PH_IDLE0)
                    begin
                        phase_next = abs_pkg::PH_WAIT0;
                    end
                    else if (phase_reg == abs_pkg::PH_IDLE1)
                    begin
                        phase_next = abs_pkg::PH_WAIT1;
                    end
                end
                abs_pkg::OP_ACK:
                begin
                    if (want_ok && req.sum_ok)
                    begin
                        priority case (phase_reg)
                            abs_pkg::PH_WAIT0:
                            begin
                                phase_next = qstat.empty ? abs_pkg::PH_IDLE1
                                                         : abs_pkg::PH_WAIT1;
                            end
                            abs_pkg::PH_WAIT1:
                            begin
                                phase_next = qstat.empty ? abs_pkg::PH_IDLE0
                                                         : abs_pkg::PH_WAIT0;
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
                abs_pkg::OP_TIMEOUT,
                abs_pkg::OP_NONE:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Request outputs: queue control, packet load and result
    always_comb
    begin
        qctl.push  = 1'b0;
        qctl.pop   = 1'b0;
        load       = 1'b0;
        from_queue = 1'b0;
        new_seq    = 1'b0;
        res        = 1'b0;
        send       = 1'b0;
        timer      = abs_pkg::TMR_NONE;
        if (adv)
        begin
            unique case (req.op)
                abs_pkg::OP_MSG:
                begin
                    if (phase_reg == abs_pkg::PH_IDLE0 || phase_reg == abs_pkg::PH_IDLE1)
                    begin
                        load       = 1'b1;
                        from_queue = !qstat.empty;
                        qctl.pop   = !qstat.empty;
                        qctl.push  = !qstat.empty;
                        new_seq    = (phase_reg == abs_pkg::PH_IDLE1);
                        res        = 1'b1;
                        send       = 1'b1;
                        timer      = abs_pkg::TMR_START;
                    end
                    else
                    begin
                        qctl.push = !qstat.full;
                    end
                end
                abs_pkg::OP_ACK:
                begin
                    if ((phase_reg == abs_pkg::PH_WAIT0 || phase_reg == abs_pkg::PH_WAIT1)
                        && want_ok && req.sum_ok)
                    begin
                        res = 1'b1;
                        if (qstat.empty)
                        begin
                            timer = abs_pkg::TMR_STOP;
                        end
                        else
                        begin
                            load       = 1'b1;
                            from_queue = 1'b1;
                            qctl.pop   = 1'b1;
                            new_seq    = (phase_reg == abs_pkg::PH_WAIT0);
                            send       = 1'b1;
                            timer      = abs_pkg::TMR_STOP_START;
                        end
                    end
                end
                abs_pkg::OP_TIMEOUT:
                begin
                    res   = 1'b1;
                    send  = 1'b1;
                    timer = abs_pkg::TMR_START;
                end
                abs_pkg::OP_NONE:
                begin
                    res = 1'b0;
                end
            endcase
        end
    end

    // New packet: payload checksum already folded, only the sequence word is added
    always_comb
    begin
        src     = from_queue ? head_data : req.msg;
        chk_sum = {1'b0, src.psum} + {16'd0, new_seq};
        last_seq_next   = last_seq_reg;
        last_check_next = last_check_reg;
        last_msg_next   = last_msg_reg;
        if (load)
        begin
            last_seq_next   = new_seq;
            last_check_next = ~(chk_sum[15:0] + {15'd0, chk_sum[16]});
            last_msg_next   = src;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= abs_pkg::PH_IDLE0;
            last_seq_reg   <= 1'b0;
            last_check_reg <= '0;
            last_msg_reg   <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            last_seq_reg   <= last_seq_next;
            last_check_reg <= last_check_next;
            last_msg_reg   <= last_msg_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res)
        begin
            send_reg  <= send;
            seq_reg   <= send & last_seq_next;
            check_reg <= send ? last_check_next    : 16'd0;
            low_reg   <= send ? last_msg_next.low  : 64'd0;
            mid_reg   <= send ? last_msg_next.mid  : 64'd0;
            high_reg  <= send ? last_msg_next.high : 32'd0;
            timer_reg <= timer;
        end
    end

    assign out_valid    = out_valid_reg;
    assign send_valid   = send_reg;
    assign out_seq      = seq_reg;
    assign out_check    = check_reg;
    assign out_low      = low_reg;
    assign out_mid      = mid_reg;
    assign out_high     = high_reg;
    assign timer_action = timer_reg;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the alternating-bit sender core.
module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RX_HOLD     = 300;

    typedef struct {
        abs_pkg::opcode_t op;
        logic [63:0]      low;
        logic [63:0]      mid;
        logic [31:0]      high;
        logic [31:0]      seq;
        logic [31:0]      ack;
        logic [31:0]      chk;
    } request_t;

    class abs_scoreboard;
        typedef struct {
            logic [63:0] low;
            logic [63:0] mid;
            logic [31:0] high;
        } frame_t;

        typedef struct {
            logic             send;
            logic             seq;
            logic [15:0]      check;
            logic [63:0]      low;
            logic [63:0]      mid;
            logic [31:0]      high;
            abs_pkg::timer_t  timer;
        } tx_result_t;

        abs_pkg::phase_t phase;
        logic            last_seq;
        logic [15:0]     last_check;
        frame_t          last_frame;
        frame_t          backlog[$];
        tx_result_t      expected_q[$];
        int              errors;

        function new();
            phase      = abs_pkg::PH_IDLE0;
            last_seq   = 1'b0;
            last_check = '0;
            last_frame = '{default: '0};
            errors     = 0;
        endfunction

        // One's-complement sum of the 32-byte packet, folded to 16 bits.
        static function logic [15:0] ones_fold(input logic [31:0] seq, input logic [31:0] ack,
                                               input logic [31:0] chk, input logic [63:0] lo,
                                               input logic [63:0] mid, input logic [31:0] hi);
            logic [255:0] pkt;
            logic [31:0]  s;
            pkt = {hi, mid, lo, chk, ack, seq};
            s   = '0;
            for (int i = 0; i < 16; i++)
                s += 32'(pkt[16*i +: 16]);
            while (s[31:16] != 0)
                s = 32'(s[31:16]) + 32'(s[15:0]);
            return s[15:0];
        endfunction

        function bit is_waiting();
            return phase == abs_pkg::PH_WAIT0 || phase == abs_pkg::PH_WAIT1;
        endfunction

        function bit waiting_bit();
            return phase == abs_pkg::PH_WAIT1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int backlog_size();
            return backlog.size();
        endfunction

        function void load_frame(input logic seq, input frame_t f);
            last_seq   = seq;
            last_frame = f;
            last_check = ~ones_fold({31'd0, seq}, 32'd0, 32'd0, f.low, f.mid, f.high);
        endfunction

        function void add_result(input logic send, input abs_pkg::timer_t t);
            tx_result_t e;
            e.send  = send;
            e.seq   = send ? last_seq : 1'b0;
            e.check = send ? last_check : 16'd0;
            e.low   = send ? last_frame.low : 64'd0;
            e.mid   = send ? last_frame.mid : 64'd0;
            e.high  = send ? last_frame.high : 32'd0;
            e.timer = t;
            expected_q.push_back(e);
        endfunction

        function void advance(input logic [1:0] step);
            logic [1:0] nxt;
            nxt   = phase + step;
            phase = abs_pkg::phase_t'(nxt);
        endfunction

        function void note_request(input request_t r);
            frame_t f;
            logic   want;
            f.low  = r.low;
            f.mid  = r.mid;
            f.high = r.high;
            case (r.op)
                abs_pkg::OP_MSG:
                begin
                    if (!is_waiting())
                    begin
                        if (backlog.size() == 0)
                            load_frame(phase == abs_pkg::PH_IDLE1, f);
                        else
                        begin
                            load_frame(phase == abs_pkg::PH_IDLE1, backlog.pop_front());
                            backlog.push_back(f);
                        end
                        advance(2'd1);
                        add_result(1'b1, abs_pkg::TMR_START);
                    end
                    else if (backlog.size() < abs_pkg::QUEUE_DEPTH)
                        backlog.push_back(f);
                end
                abs_pkg::OP_ACK:
                begin
                    if (is_waiting())
                    begin
                        want = waiting_bit();
                        if (r.ack == {31'd0, want} &&
                            ones_fold(r.seq, r.ack, r.chk, r.low, r.mid, r.high) == 16'hffff)
                        begin
                            if (backlog.size() == 0)
                            begin
                                advance(2'd1);
                                add_result(1'b0, abs_pkg::TMR_STOP);
                            end
                            else
                            begin
                                load_frame(!want, backlog.pop_front());
                                advance(2'd2);
                                add_result(1'b1, abs_pkg::TMR_STOP_START);
                            end
                        end
                    end
                end
                abs_pkg::OP_TIMEOUT: add_result(1'b1, abs_pkg::TMR_START);
                default: ;
            endcase
        endfunction

        function void compare_field(input string name, input logic [63:0] exp_v,
                                    input logic [63:0] act_v);
            if (act_v !== exp_v)
            begin
                $error("%s: expected %h, got %h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(input logic send, input logic seq, input logic [15:0] check,
                                   input logic [63:0] low, input logic [63:0] mid,
                                   input logic [31:0] high, input logic [1:0] timer);
            tx_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("result with none pending: send_valid %b timer_action %0d", send, timer);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare_field("send_valid", 64'(e.send), 64'(send));
            compare_field("out_seq", 64'(e.seq), 64'(seq));
            compare_field("out_check", 64'(e.check), 64'(check));
            compare_field("out_low", e.low, low);
            compare_field("out_mid", e.mid, mid);
            compare_field("out_high", 64'(e.high), 64'(high));
            compare_field("timer_action", 64'(e.timer), 64'(timer));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [63:0] payload_low;
    logic [63:0] payload_mid;
    logic [31:0] payload_high;
    logic [31:0] pkt_seq;
    logic [31:0] pkt_ack;
    logic [31:0] pkt_check;
    logic        out_valid;
    logic        out_ready;
    logic        send_valid;
    logic        out_seq;
    logic [15:0] out_check;
    logic [63:0] out_low;
    logic [63:0] out_mid;
    logic [31:0] out_high;
    logic [1:0]  timer_action;

    bit          rx_hold_req;
    bit          rx_holding;
    int unsigned cycle_count;

    abs_scoreboard sb;

    alternating_bit_sender_core i_dut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [63:0] rnd64();
        int r;
        r = $urandom_range(15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] rnd32();
        int r;
        r = $urandom_range(15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(25, 8);
    endfunction

    function automatic request_t plain_req(input abs_pkg::opcode_t op);
        request_t r;
        r.op   = op;
        r.low  = rnd64();
        r.mid  = rnd64();
        r.high = rnd32();
        r.seq  = rnd32();
        r.ack  = rnd32();
        r.chk  = rnd32();
        return r;
    endfunction

    function automatic request_t msg_req(input logic [63:0] lo, input logic [63:0] mid,
                                         input logic [31:0] hi);
        request_t r;
        r      = plain_req(abs_pkg::OP_MSG);
        r.low  = lo;
        r.mid  = mid;
        r.high = hi;
        return r;
    endfunction

    // Ack packet; the low check half is solved so the packet sums to zero,
    // then a single flipped bit breaks it when a bad checksum is wanted.
    function automatic request_t ack_req(input logic [31:0] ack_word, input bit good_sum,
                                         input logic [63:0] lo, input logic [63:0] mid,
                                         input logic [31:0] hi);
        request_t    r;
        logic [15:0] partial;
        logic [15:0] chk_hi;
        r.op    = abs_pkg::OP_ACK;
        r.low   = lo;
        r.mid   = mid;
        r.high  = hi;
        r.seq   = rnd32();
        r.ack   = ack_word;
        chk_hi  = 16'($urandom);
        partial = abs_scoreboard::ones_fold(r.seq, ack_word, {chk_hi, 16'd0}, lo, mid, hi);
        r.chk   = {chk_hi, ~partial};
        if (!good_sum)
            r.chk = r.chk ^ (32'd1 << $urandom_range(31));
        return r;
    endfunction

    function automatic request_t good_ack();
        return ack_req({31'd0, sb.waiting_bit()}, 1'b1, rnd64(), rnd64(), rnd32());
    endfunction

    task automatic issue(input request_t r, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= r.op;
        payload_low  <= r.low;
        payload_mid  <= r.mid;
        payload_high <= r.high;
        pkt_seq      <= r.seq;
        pkt_ack      <= r.ack;
        pkt_check    <= r.chk;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(r);
    endtask

    // Receiver: random stalls, plus one long hold-off on request from the sender side.
    initial
    begin
        int n;
        out_ready   = 1'b0;
        rx_holding  = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                rx_holding  = 1'b1;
                out_ready   <= 1'b0;
                repeat (RX_HOLD) @(posedge clk);
                rx_holding  = 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(40, 1)) @(posedge clk);
                n = pick_gap();
                if (n > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(send_valid, out_seq, out_check, out_low, out_mid, out_high,
                            timer_action);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        int       r;
        int       g;
        request_t req;
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = abs_pkg::OP_NONE;
        payload_low  = '0;
        payload_mid  = '0;
        payload_high = '0;
        pkt_seq      = '0;
        pkt_ack      = '0;
        pkt_check    = '0;
        rx_hold_req  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed walk through every phase
        issue(plain_req(abs_pkg::OP_TIMEOUT), pick_gap());  // resend of all-zero packet
        issue(good_ack(), pick_gap());                      // ack while idle
        issue(plain_req(abs_pkg::OP_NONE), pick_gap());
        issue(msg_req('1, '1, '1), pick_gap());             // sent with seq 0
        issue(plain_req(abs_pkg::OP_TIMEOUT), pick_gap());
        issue(ack_req(32'd1, 1'b1, rnd64(), rnd64(), rnd32()), pick_gap());   // wrong bit
        issue(ack_req(32'hffff_fffe, 1'b1, rnd64(), rnd64(), rnd32()), pick_gap());
        issue(ack_req(32'd0, 1'b0, rnd64(), rnd64(), rnd32()), pick_gap());   // bad sum
        issue(msg_req('0, '0, '0), pick_gap());             // queued
        issue(msg_req(rnd64(), rnd64(), rnd32()), pick_gap());
        issue(good_ack(), pick_gap());                      // pops, sends seq 1
        issue(plain_req(abs_pkg::OP_TIMEOUT), pick_gap());
        issue(good_ack(), pick_gap());                      // pops, sends seq 0
        issue(ack_req(32'd0, 1'b1, '1, '1, '1), pick_gap());   // queue empty: stop timer
        issue(plain_req(abs_pkg::OP_TIMEOUT), pick_gap());
        issue(ack_req(32'd1, 1'b1, '0, '0, '0), pick_gap());   // ack while idle
        issue(msg_req(rnd64(), rnd64(), rnd32()), pick_gap());
        issue(plain_req(abs_pkg::OP_NONE), pick_gap());
        issue(ack_req(32'd1, 1'b1, '0, '0, '0), pick_gap());

        for (int i = 0; i < 400; i++)
        begin
            if (i == 120 || i == 330)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (sb.pending() != 0);
            end
            if (i == 150)
            begin
                // output held off while requests keep coming
                in_valid    <= 1'b0;
                rx_hold_req = 1'b1;
                do
                    @(posedge clk);
                while (!rx_holding);
                for (int k = 0; k < 24; k++)
                    issue(plain_req(abs_pkg::OP_TIMEOUT), 0);
            end
            g = (i >= 200 && i < 260) ? 0 : pick_gap();
            r = $urandom_range(99);
            if (r < 40 || (r < 74 && !sb.is_waiting()))
                req = msg_req(rnd64(), rnd64(), rnd32());
            else if (r < 74)
                req = good_ack();
            else if (r < 81)
                req = ack_req($urandom, 1'b1, rnd64(), rnd64(), rnd32());
            else if (r < 88)
                req = ack_req({31'd0, sb.waiting_bit()}, 1'b0, rnd64(), rnd64(), rnd32());
            else if (r < 96)
                req = plain_req(abs_pkg::OP_TIMEOUT);
            else
                req = plain_req(abs_pkg::OP_NONE);
            issue(req, g);
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

/* alternating_bit_sender_core.f */
rtl/abs_pkg.sv
rtl/abs_front.sv
rtl/abs_queue.sv
rtl/alternating_bit_sender_core.sv
sim/tb_top.sv
